### rtl/mscs_pkg.sv
// Package: widths, endpoint codes and case table for the marching-squares cell block.
`default_nettype none
package mscs_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned FracW  = 12;
  // Q.12 products kept to 33 bits signed (clamp range +-2^31)
  localparam int unsigned MonoW  = 33;
  localparam int unsigned SumW   = 48;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [MonoW-1:0]  mono_t;
  typedef logic signed [SumW-1:0]   acc_t;

  typedef enum logic [1:0] {
    PtLeft   = 2'd0,
    PtBottom = 2'd1,
    PtRight  = 2'd2,
    PtTop    = 2'd3
  } pt_e;

  typedef struct packed {
    logic [1:0] count;
    pt_e        s0;
    pt_e        e0;
    pt_e        s1;
    pt_e        e1;
  } seg_entry_t;

  function automatic seg_entry_t case_lookup(input logic [3:0] c);
    seg_entry_t r;
    r = '{count: 2'd0, s0: PtLeft, e0: PtLeft, s1: PtLeft, e1: PtLeft};
    case (c)
      4'd1, 4'd14: r = '{2'd1, PtLeft, PtBottom, PtLeft, PtLeft};
      4'd2, 4'd13: r = '{2'd1, PtBottom, PtRight, PtLeft, PtLeft};
      4'd3, 4'd12: r = '{2'd1, PtLeft, PtRight, PtLeft, PtLeft};
      4'd4, 4'd11: r = '{2'd1, PtTop, PtRight, PtLeft, PtLeft};
      4'd5:        r = '{2'd2, PtLeft, PtTop, PtBottom, PtRight};
      4'd6, 4'd9:  r = '{2'd1, PtBottom, PtTop, PtLeft, PtLeft};
      4'd7, 4'd8:  r = '{2'd1, PtLeft, PtTop, PtLeft, PtLeft};
      4'd10:       r = '{2'd2, PtTop, PtRight, PtLeft, PtBottom};
      default:     r = '{count: 2'd0, s0: PtLeft, e0: PtLeft, s1: PtLeft, e1: PtLeft};
    endcase
    return r;
  endfunction

  // Floor of a Q.12 product, clamped to +-2^31.
  function automatic mono_t qmul(input mono_t a, input mono_t b);
    logic signed [2*MonoW-1:0] p;
    logic signed [2*MonoW-1:0] q;
    mono_t r;
    p = a * b;
    q = p >>> FracW;
    if (q > 66'sh0_8000_0000) r = 33'sh0_8000_0000;
    else if (q < -66'sh0_8000_0000) r = -33'sh0_8000_0000;
    else r = q[MonoW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/marching_squares_cell_segments.sv
// Top level: marching-squares cell to midpoint contour segments, pipelined.
//
// Usage:
//  - s_axis carries one cell per transaction: tdata = {y_top, x_right, y_bottom, x_left},
//    x_left in the lowest 16 bits, all signed Q4.12.
//  - m_axis carries one segment per transaction: tdata packs start_x, start_y,
//    end_x, end_y (16 bits each from bit 0) and cell_case in bits 67:64, padded
//    to 72 bits; tlast marks the last segment of a cell.
//  - Four corners are evaluated in parallel lanes over four register stages:
//    first-order/quadratic products, cubic products, quartic products, then
//    the weighted sum and sign. A fifth stage looks up the case table and forms the endpoints.
//  - Throughput: one cell per cycle for cases with no or one segment while the
//    receiver does not stall; a saddle case holds the pipeline while the single
//    output register sends its two segments.
//  - Uniform cells (all four corners on the same side) produce no transaction.
//  - When the receiver stalls, the pipeline holds once stage 3 holds a cell;
//    nothing is lost or repeated. Reset clears all valid bits and the segment index.
`default_nettype none
module marching_squares_cell_segments (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output       logic        s_axis_tready,
  input  wire  logic [63:0] s_axis_tdata,  // x_left, y_bottom, x_right, y_top
  output       logic        m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output       logic [71:0] m_axis_tdata,  // start_x, start_y, end_x, end_y, cell_case
  output       logic        m_axis_tlast   // last_segment
);
  import mscs_pkg::*;

  localparam int unsigned NStg = 4;

  // Pipeline advances when stage 3 is empty or the output stage can take its item.
  logic adv;
  logic [NStg-1:0] vld_q;

  // first member sits in the highest bits: x_left ends up in tdata[15:0]
  typedef struct packed {
    coord_t yt, xr, yb, xl;
  } cell_t;

  cell_t  cell_q [NStg];
  // per-corner monomials: corners 0 BL, 1 BR, 2 TR, 3 TL
  mono_t  x_q  [4], y_q  [4];
  mono_t  x2_q [4], xy_q [4], y2_q [4];
  mono_t  x3_q [4], x2y_q[4], xy2_q[4], y3_q[4];
  mono_t  x2b_q[4], xb_q [4], yb_q [4], y2b_q[4], x2c_q[4], xyc_q[4], y2c_q[4];
  mono_t  x4_q [4], x3y_q[4], x2y2_q[4], xy3_q[4], y4_q[4];
  acc_t   lo_q [4];
  logic [3:0] case_q;

  // Output register and saddle second-segment index
  logic        out_vld_q;
  logic        seg_idx_q;
  seg_entry_t  ent;
  logic        out_free;
  logic        stg4_done;

  assign out_free  = !out_vld_q || m_axis_tready;
  // the stage-3 item leaves when its final segment (or nothing) is loaded
  assign stg4_done = !vld_q[3] || (out_free &&
                     (ent.count != 2'd2 || seg_idx_q));
  assign adv = stg4_done;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: capture cell and build corner coordinates, first products
  cell_t cin;
  assign cin = s_axis_tdata;

  mono_t cx [4], cy [4];
  always_comb begin
    cx[0] = mono_t'(cin.xl); cy[0] = mono_t'(cin.yb);
    cx[1] = mono_t'(cin.xr); cy[1] = mono_t'(cin.yb);
    cx[2] = mono_t'(cin.xr); cy[2] = mono_t'(cin.yt);
    cx[3] = mono_t'(cin.xl); cy[3] = mono_t'(cin.yt);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cell_q[0] <= cin;
      for (int i = 1; i < NStg; i++) cell_q[i] <= cell_q[i-1];
      for (int c = 0; c < 4; c++) begin
        // stage 0
        x_q[c]  <= cx[c];
        y_q[c]  <= cy[c];
        x2_q[c] <= qmul(cx[c], cx[c]);
        xy_q[c] <= qmul(cx[c], cy[c]);
        y2_q[c] <= qmul(cy[c], cy[c]);
        // stage 1: cubics
        x3_q[c]  <= qmul(x2_q[c], x_q[c]);
        x2y_q[c] <= qmul(x2_q[c], y_q[c]);
        xy2_q[c] <= qmul(x_q[c], y2_q[c]);
        y3_q[c]  <= qmul(y2_q[c], y_q[c]);
        x2b_q[c] <= x2_q[c];
        xb_q[c]  <= x_q[c];
        yb_q[c]  <= y_q[c];
        y2b_q[c] <= y2_q[c];
        x2c_q[c] <= x2_q[c];
        xyc_q[c] <= xy_q[c];
        y2c_q[c] <= y2_q[c];
        // stage 2: quartics plus low-order partial sum
        x4_q[c]   <= qmul(x3_q[c], xb_q[c]);
        x3y_q[c]  <= qmul(x3_q[c], yb_q[c]);
        x2y2_q[c] <= qmul(x2b_q[c], y2b_q[c]);
        xy3_q[c]  <= qmul(xb_q[c], y3_q[c]);
        y4_q[c]   <= qmul(y3_q[c], yb_q[c]);
        lo_q[c] <= acc_t'(16384)
                 + acc_t'(110) * acc_t'(xb_q[c]) - acc_t'(177) * acc_t'(yb_q[c])
                 - acc_t'(174) * acc_t'(x2c_q[c]) + acc_t'(224) * acc_t'(xyc_q[c])
                 - acc_t'(303) * acc_t'(y2c_q[c])
                 - acc_t'(168) * acc_t'(x3_q[c]) + acc_t'(327) * acc_t'(x2y_q[c])
                 - acc_t'(87) * acc_t'(xy2_q[c]) - acc_t'(13) * acc_t'(y3_q[c]);
        // stage 3: quartic terms and sign
        case_q[c] <= (lo_q[c]
                 + acc_t'(235) * acc_t'(x4_q[c]) - acc_t'(667) * acc_t'(x3y_q[c])
                 + acc_t'(745) * acc_t'(x2y2_q[c]) - acc_t'(29) * acc_t'(xy3_q[c])
                 + acc_t'(72) * acc_t'(y4_q[c])) > acc_t'(0);
      end
    end
  end

  // Stage 4: table lookup and endpoint selection
  coord_t xm, ym, px [4], py [4];
  logic signed [CoordW:0] xs, ys;
  cell_t c4;
  pt_e sa, sb;
  assign c4 = cell_q[3];
  assign ent = case_lookup(case_q);
  always_comb begin
    xs = {c4.xl[CoordW-1], c4.xl} + {c4.xr[CoordW-1], c4.xr};
    ys = {c4.yb[CoordW-1], c4.yb} + {c4.yt[CoordW-1], c4.yt};
    xm = xs[CoordW:1];
    ym = ys[CoordW:1];
    px[PtLeft]   = c4.xl; py[PtLeft]   = ym;
    px[PtBottom] = xm;    py[PtBottom] = c4.yb;
    px[PtRight]  = c4.xr; py[PtRight]  = ym;
    px[PtTop]    = xm;    py[PtTop]    = c4.yt;
    sa = seg_idx_q ? ent.s1 : ent.s0;
    sb = seg_idx_q ? ent.e1 : ent.e0;
  end

  // Output register: load a segment whenever free and stage 3 holds one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      seg_idx_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= vld_q[3] && ent.count != 2'd0;
      if (vld_q[3] && ent.count == 2'd2) seg_idx_q <= !seg_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && vld_q[3] && ent.count != 2'd0) begin
      m_axis_tdata <= {4'd0, case_q, py[sb], px[sb], py[sa], px[sa]};
      m_axis_tlast <= (ent.count == 2'd1) || seg_idx_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;

  // Hold the output transaction while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // Second saddle segment follows only a first one
  a_saddle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_idx_q |-> vld_q[3] && out_vld_q && !m_axis_tlast)
    else $error("saddle index without first segment");
  // Uniform cases never produce output
  a_uniform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[67:64] != 4'd0 && m_axis_tdata[67:64] != 4'd15)
    else $error("uniform cell emitted a segment");

endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for the marching-squares cell block: directed table then random cells, predicted.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mscs_pkg::*;

  typedef struct {
    logic signed [15:0] sx, sy, ex, ey;
    logic [3:0]         ccase;
    logic               last;
  } segment_t;

  // Directed row: a cell, and optionally a hand-typed case index to expect.
  typedef struct {
    logic [15:0] xl, yb, xr, yt;
    bit          typed;
    logic [3:0]  ccase;
  } cell_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  segment_t segment_q[$];
  int       errors = 0;
  bit       quiet = 1'b0;

  marching_squares_cell_segments uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  // Floored Q.12 product, clamped to +-2^31.
  function automatic longint fix_mul(longint a, longint b);
    longint p, q;
    p = a * b;
    q = p >>> 12;
    if (q > 64'sd2147483648) q = 64'sd2147483648;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic bit corner_above(longint x, longint y);
    longint x2, xy, y2, x3, x2y, xy2, y3, x4, x3y, x2y2, xy3, y4, s;
    x2 = fix_mul(x, x); xy = fix_mul(x, y); y2 = fix_mul(y, y);
    x3 = fix_mul(x2, x); x2y = fix_mul(x2, y); xy2 = fix_mul(x, y2); y3 = fix_mul(y2, y);
    x4 = fix_mul(x3, x); x3y = fix_mul(x3, y); x2y2 = fix_mul(x2, y2);
    xy3 = fix_mul(x, y3); y4 = fix_mul(y3, y);
    s = 4 * 4096 + 110 * x - 177 * y - 174 * x2 + 224 * xy - 303 * y2
        - 168 * x3 + 327 * x2y - 87 * xy2 - 13 * y3
        + 235 * x4 - 667 * x3y + 745 * x2y2 - 29 * xy3 + 72 * y4;
    return s > 0;
  endfunction

  // Work out the case index and queue the segments the cell yields.
  function automatic logic [3:0] predict_cell(logic [15:0] rxl, logic [15:0] ryb,
                                              logic [15:0] rxr, logic [15:0] ryt);
    longint xl, yb, xr, yt, xm, ym;
    longint px[4], py[4];
    logic [3:0] c;
    pt_e pts[4];
    int n;
    segment_t s;
    xl = longint'($signed(rxl)); yb = longint'($signed(ryb));
    xr = longint'($signed(rxr)); yt = longint'($signed(ryt));
    xm = (xl + xr) >>> 1;
    ym = (yb + yt) >>> 1;
    c = {corner_above(xl, yt), corner_above(xr, yt), corner_above(xr, yb),
         corner_above(xl, yb)};
    px[PtLeft] = xl;   py[PtLeft] = ym;
    px[PtBottom] = xm; py[PtBottom] = yb;
    px[PtRight] = xr;  py[PtRight] = ym;
    px[PtTop] = xm;    py[PtTop] = yt;
    n = 1;
    case (c)
      4'd0, 4'd15: n = 0;
      4'd1, 4'd14: pts = '{PtLeft, PtBottom, PtLeft, PtLeft};
      4'd2, 4'd13: pts = '{PtBottom, PtRight, PtLeft, PtLeft};
      4'd3, 4'd12: pts = '{PtLeft, PtRight, PtLeft, PtLeft};
      4'd4, 4'd11: pts = '{PtTop, PtRight, PtLeft, PtLeft};
      4'd6, 4'd9:  pts = '{PtBottom, PtTop, PtLeft, PtLeft};
      4'd7, 4'd8:  pts = '{PtLeft, PtTop, PtLeft, PtLeft};
      4'd5: begin
        n = 2; pts = '{PtLeft, PtTop, PtBottom, PtRight};
      end
      default: begin
        n = 2; pts = '{PtTop, PtRight, PtLeft, PtBottom};
      end
    endcase
    for (int k = 0; k < n; k++) begin
      s.sx = px[pts[2*k]][15:0];   s.sy = py[pts[2*k]][15:0];
      s.ex = px[pts[2*k+1]][15:0]; s.ey = py[pts[2*k+1]][15:0];
      s.ccase = c;
      s.last = (k == n - 1);
      segment_q = {segment_q, s};
    end
    return c;
  endfunction

  // Random receiver stalls in bursts; none once quiet is set.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each segment transaction with the oldest expectation.
  always @(posedge clk_i) begin
    segment_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sx = m_axis_tdata[15:0];  got.sy = m_axis_tdata[31:16];
      got.ex = m_axis_tdata[47:32]; got.ey = m_axis_tdata[63:48];
      got.ccase = m_axis_tdata[67:64];
      got.last = m_axis_tlast;
      if (segment_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment %p", $time, got);
      end else begin
        want = segment_q.pop_front();
        if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
            got.ey !== want.ey || got.ccase !== want.ccase || got.last !== want.last) begin
          errors++;
          $display("%0t: segment mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
  end

  // Hand one cell over, with an optional random gap first.
  task automatic send_cell(logic [15:0] xl, logic [15:0] yb, logic [15:0] xr,
                           logic [15:0] yt, output logic [3:0] c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yt, xr, yb, xl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    c = predict_cell(xl, yb, xr, yt);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16384)) - 8192);
      default: return 16'($signed($urandom_range(0, 6144)) - 3072);
    endcase
  endfunction

  initial begin
    cell_row_t rows[$];
    logic [3:0] c;
    logic [15:0] xl, yb, w, h;
    // Origin corners sit just above zero (constant term), large magnitudes
    // are dominated by the quartic terms.
    rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 4'd15},
      '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, 4'd0},
      '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b0, 4'd0},
      '{16'h8000, 16'h0000, 16'h7fff, 16'h0000, 1'b0, 4'd0},
      '{16'h0000, 16'h8000, 16'h0000, 16'h7fff, 1'b0, 4'd0},
      '{16'hf000, 16'hf000, 16'h1000, 16'h1000, 1'b0, 4'd0},
      '{16'h0000, 16'h0000, 16'h1000, 16'h1000, 1'b0, 4'd0},
      '{16'hf800, 16'hf800, 16'h0800, 16'h0800, 1'b0, 4'd0},
      '{16'h0400, 16'h0400, 16'h0200, 16'h0200, 1'b0, 4'd0},
      '{16'hffff, 16'hffff, 16'h0001, 16'h0001, 1'b0, 4'd0},
      '{16'h0000, 16'hf000, 16'h2000, 16'h0000, 1'b0, 4'd0},
      '{16'hc000, 16'h4000, 16'h4000, 16'hc000, 1'b0, 4'd0},
      '{16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1'b0, 4'd0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_cell(rows[i].xl, rows[i].yb, rows[i].xr, rows[i].yt, c);
      if (rows[i].typed && c !== rows[i].ccase) begin
        errors++;
        $display("%0t: case mismatch, expected %0d, actual %0d", $time, rows[i].ccase, c);
      end
    end
    // Mostly small cells near the contour, so that all cases and saddles occur.
    for (int n = 0; n < 1350; n++) begin
      if (n > 1200) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        send_cell(rand_coord(), rand_coord(), rand_coord(), rand_coord(), c);
      end else begin
        xl = 16'($signed($urandom_range(0, 12288)) - 6144);
        yb = 16'($signed($urandom_range(0, 12288)) - 6144);
        w = 16'($urandom_range(1, 3000));
        h = 16'($urandom_range(1, 3000));
        send_cell(xl, yb, xl + w, yb + h, c);
      end
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b1;
    while (segment_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
